### rtl/websocket_frame_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// websocket frame encoder assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_ENCODER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define WSFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfe assertion failed");

// next-cycle implication
`define WSFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfe assertion failed");

`endif

### rtl/wsfe_pkg.sv
// ----------------------------------------------------------------------------
// wsfe_pkg
// widths, codes and header constants of the websocket frame encoder
// ----------------------------------------------------------------------------
package wsfe_pkg;

    localparam int LEN_W       = 63;
    localparam int KEY_W       = 32;
    localparam int OPC_W       = 4;
    localparam int HDR_BYTES   = 14;
    localparam int HDR_CNT_W   = 4;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_USER_W  = 2;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    localparam int USER_FRAME_END = 0;
    localparam int USER_ERROR     = 1;

    localparam logic [LEN_W-1:0] LEN_SHORT_MAX  = LEN_W'(125);
    localparam logic [LEN_W-1:0] LEN_MEDIUM_MAX = LEN_W'(65535);
    localparam logic [6:0]       CODE_LEN16     = 7'd126;
    localparam logic [6:0]       CODE_LEN64     = 7'd127;
    localparam logic [7:0]       FLAG_BIT       = 8'h80;

    localparam logic [HDR_CNT_W-1:0] LAST_SHORT  = HDR_CNT_W'(5);
    localparam logic [HDR_CNT_W-1:0] LAST_MEDIUM = HDR_CNT_W'(7);
    localparam logic [HDR_CNT_W-1:0] LAST_LONG   = HDR_CNT_W'(13);

    typedef logic [7:0] byte_t;

endpackage

### rtl/websocket_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_encoder_core
// masked client websocket frame encoder: header burst and masked payload bytes
// ----------------------------------------------------------------------------
// path: an input transfer goes into the item register, then the output register
// payload item: one transfer in and one out every cycle while the sink is ready
// start item: 6, 8 or 14 header bytes, sent one by one through the byte lane
// reset: rst_n async low, clears frame state (length, key, key index) to zero
// ----------------------------------------------------------------------------
`include "websocket_frame_encoder_core_defines.svh"

module websocket_frame_encoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // opcode[3:0], payload_length[66:4], mask_key[98:67], payload_byte[106:99], zero
    input  logic [wsfe_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte
    output logic [7:0]                    m_axis_tdata,
    output logic                          m_axis_tlast,
    // frame_end[0], error[1]
    output logic [wsfe_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import wsfe_pkg::*;

    logic [OPC_W-1:0] in_opcode;
    logic [LEN_W-1:0] in_len;
    logic [KEY_W-1:0] in_key;
    byte_t            in_byte;

    assign in_opcode = s_axis_tdata[3:0];
    assign in_len    = s_axis_tdata[66:4];
    assign in_key    = s_axis_tdata[98:67];
    assign in_byte   = s_axis_tdata[106:99];

    // item register
    logic                 a_valid_reg;
    logic                 a_mode_reg;
    byte_t                a_byte_reg;
    byte_t                a_hdr_reg [HDR_BYTES];
    logic [HDR_CNT_W-1:0] a_left_reg;
    logic [LEN_W-1:0]     a_len_reg;
    logic [KEY_W-1:0]     a_key_reg;
    logic                 a_len_zero_reg;

    // frame state
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [KEY_W-1:0] key_store_reg, key_store_next;
    logic [1:0]       key_index_reg, key_index_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    byte_t                 m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;

    byte_t                hdr_next [HDR_BYTES];
    logic [HDR_CNT_W-1:0] left_next;
    logic [63:0]          len64;
    logic                 out_ok;
    logic                 emit;
    logic                 a_last;
    logic                 s_accept;
    byte_t                key_byte;
    logic                 no_frame;

    assign out_ok        = !m_valid_reg || m_axis_tready;
    assign emit          = a_valid_reg && out_ok;
    assign a_last        = (a_mode_reg == MODE_PAYLOAD) || (a_left_reg == '0);
    assign s_axis_tready = !a_valid_reg || (emit && a_last);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign len64         = {1'b0, in_len};
    assign key_byte      = key_store_reg[{key_index_reg, 3'b000} +: 8];
    assign no_frame      = (bytes_left_reg == '0);

    // header assembly for a start item
    always_comb
    begin
        for (int j = 0; j < HDR_BYTES; j++)
        begin
            hdr_next[j] = '0;
        end
        hdr_next[0] = FLAG_BIT | {4'b0000, in_opcode};
        if (in_len <= LEN_SHORT_MAX)
        begin
            hdr_next[1] = {1'b1, in_len[6:0]};
            for (int j = 0; j < 4; j++)
            begin
                hdr_next[2 + j] = in_key[8*j +: 8];
            end
            left_next = LAST_SHORT;
        end
        else if (in_len <= LEN_MEDIUM_MAX)
        begin
            hdr_next[1] = {1'b1, CODE_LEN16};
            hdr_next[2] = in_len[15:8];
            hdr_next[3] = in_len[7:0];
            for (int j = 0; j < 4; j++)
            begin
                hdr_next[4 + j] = in_key[8*j +: 8];
            end
            left_next = LAST_MEDIUM;
        end
        else
        begin
            hdr_next[1] = {1'b1, CODE_LEN64};
            for (int j = 0; j < 8; j++)
            begin
                hdr_next[2 + j] = len64[8*(7-j) +: 8];
            end
            for (int j = 0; j < 4; j++)
            begin
                hdr_next[10 + j] = in_key[8*j +: 8];
            end
            left_next = LAST_LONG;
        end
    end

    // result byte and frame state update
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        key_store_next  = key_store_reg;
        key_index_next  = key_index_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;
        if (out_ok)
        begin
            m_valid_next = emit;
        end
        if (emit)
        begin
            m_user_next = '0;
            case (a_mode_reg)
                MODE_PAYLOAD:
                begin
                    m_last_next = 1'b1;
                    if (no_frame)
                    begin
                        m_data_next             = '0;
                        m_user_next[USER_ERROR] = 1'b1;
                    end
                    else
                    begin
                        m_data_next                 = a_byte_reg ^ key_byte;
                        m_user_next[USER_FRAME_END] = (bytes_left_reg == LEN_W'(1));
                        bytes_left_next             = bytes_left_reg - LEN_W'(1);
                        key_index_next              = key_index_reg + 2'd1;
                    end
                end
                default:
                begin
                    m_data_next                 = a_hdr_reg[0];
                    m_last_next                 = a_last;
                    m_user_next[USER_FRAME_END] = a_last && a_len_zero_reg;
                    if (a_last)
                    begin
                        bytes_left_next = a_len_reg;
                        key_store_next  = a_key_reg;
                        key_index_next  = '0;
                    end
                end
            endcase
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            bytes_left_reg <= '0;
            key_store_reg  <= '0;
            key_index_reg  <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (emit && a_last)
            begin
                a_valid_reg <= 1'b0;
            end
            m_valid_reg    <= m_valid_next;
            bytes_left_reg <= bytes_left_next;
            key_store_reg  <= key_store_next;
            key_index_reg  <= key_index_next;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
        if (s_accept)
        begin
            a_mode_reg     <= s_axis_tuser;
            a_byte_reg     <= in_byte;
            a_len_reg      <= in_len;
            a_key_reg      <= in_key;
            a_len_zero_reg <= (in_len == '0);
            a_left_reg     <= left_next;
            for (int j = 0; j < HDR_BYTES; j++)
            begin
                a_hdr_reg[j] <= hdr_next[j];
            end
        end
        else if (emit && !a_last)
        begin
            a_left_reg <= a_left_reg - HDR_CNT_W'(1);
            for (int j = 0; j < HDR_BYTES - 1; j++)
            begin
                a_hdr_reg[j] <= a_hdr_reg[j + 1];
            end
            a_hdr_reg[HDR_BYTES - 1] <= '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    `WSFE_ASSERT_NEXT(a_item_held, a_valid_reg && !(emit && a_last), a_valid_reg)
    `WSFE_ASSERT_NOW(error_ends_run, m_valid_reg && m_user_reg[USER_ERROR],
        m_last_reg && !m_user_reg[USER_FRAME_END])
    `WSFE_ASSERT_NEXT(frame_end_clears_len,
        emit && (a_mode_reg == MODE_PAYLOAD) && (bytes_left_reg == LEN_W'(1)),
        (bytes_left_reg == '0) && m_user_reg[USER_FRAME_END])
    `WSFE_ASSERT_NEXT(header_count_steps, emit && !a_last,
        a_left_reg == $past(a_left_reg) - HDR_CNT_W'(1))

endmodule

### tb/sv/tb_websocket_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_encoder_core
// self-checking bench for the masked client websocket frame encoder: start and
// payload transfers go in on the slave stream; every header and masked payload
// byte is predicted in the bench and compared with the master stream in order
// ----------------------------------------------------------------------------
module tb_websocket_frame_encoder_core;

    import wsfe_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        byte_t data;
        logic  last;
        logic  frame_end;
        logic  err;
    } frame_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // encoder state as seen by the bench
    logic [LEN_W-1:0] frame_left;
    logic [KEY_W-1:0] frame_key;
    logic [1:0]       key_pos;

    frame_byte_t pending_frame_bytes[$];
    int          mismatch_count;
    int          idle_cycles;
    int          sent_items;
    bit          send_gaps;
    bit          sink_gaps;
    int          hold_len;
    int          stall_left;

    websocket_frame_encoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic predict_encoded_bytes(input logic md, input logic [OPC_W-1:0] opc,
                                         input logic [LEN_W-1:0] len,
                                         input logic [KEY_W-1:0] key, input byte_t pb);
        byte_t       hdr[$];
        logic [63:0] len64;
        frame_byte_t fb;
        byte_t       kb;
        if (md == MODE_PAYLOAD)
        begin
            if (frame_left == '0)
            begin
                fb = '{data: 8'h00, last: 1'b1, frame_end: 1'b0, err: 1'b1};
            end
            else
            begin
                kb = frame_key[8*key_pos +: 8];
                frame_left = frame_left - 1'b1;
                key_pos = key_pos + 1'b1;
                fb = '{data: pb ^ kb, last: 1'b1, frame_end: (frame_left == '0), err: 1'b0};
            end
            pending_frame_bytes.push_back(fb);
        end
        else
        begin
            len64 = {1'b0, len};
            hdr.push_back(FLAG_BIT | {4'b0, opc});
            if (len <= LEN_SHORT_MAX)
            begin
                hdr.push_back(FLAG_BIT | {1'b0, len[6:0]});
            end
            else if (len <= LEN_MEDIUM_MAX)
            begin
                hdr.push_back(FLAG_BIT | {1'b0, CODE_LEN16});
                hdr.push_back(len64[15:8]);
                hdr.push_back(len64[7:0]);
            end
            else
            begin
                hdr.push_back(FLAG_BIT | {1'b0, CODE_LEN64});
                for (int i = 7; i >= 0; i--)
                begin
                    hdr.push_back(len64[8*i +: 8]);
                end
            end
            for (int i = 0; i < 4; i++)
            begin
                hdr.push_back(key[8*i +: 8]);
            end
            frame_key = key;
            key_pos = 2'd0;
            frame_left = len;
            foreach (hdr[i])
            begin
                fb.data = hdr[i];
                fb.last = (i == hdr.size() - 1);
                fb.frame_end = fb.last && (len == '0);
                fb.err = 1'b0;
                pending_frame_bytes.push_back(fb);
            end
        end
    endtask

    // called at a rising edge; returns at the edge where the transfer happened
    task automatic send_item(input logic md, input logic [OPC_W-1:0] opc,
                             input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key,
                             input byte_t pb);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= {5'b0, pb, key, len, opc};
        @(negedge clk);
        while (!s_axis_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        predict_encoded_bytes(md, opc, len, key, pb);
        sent_items++;
    endtask

    task automatic send_start(input logic [OPC_W-1:0] opc, input logic [LEN_W-1:0] len,
                              input logic [KEY_W-1:0] key);
        send_item(MODE_START, opc, len, key, byte_t'($urandom));
    endtask

    task automatic send_payload(input byte_t pb);
        send_item(MODE_PAYLOAD, OPC_W'($urandom), LEN_W'({$urandom, $urandom}), $urandom, pb);
    endtask

    task automatic send_random_frame();
        logic [LEN_W-1:0] len;
        int               pick;
        int               n_pay;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            len = LEN_W'($urandom_range(0, 20));
        end
        else if (pick == 6)
        begin
            len = LEN_W'($urandom_range(21, 125));
        end
        else if (pick == 7)
        begin
            len = LEN_W'($urandom_range(126, 65535));
        end
        else
        begin
            len = LEN_W'({$urandom, $urandom} >> $urandom_range(0, 46));
            if (len <= LEN_MEDIUM_MAX)
            begin
                len = LEN_MEDIUM_MAX + 1'b1;
            end
        end
        n_pay = (len <= 20) ? int'(len) : $urandom_range(0, 12);
        pick = $urandom_range(0, 9);
        // abandoned frame: a new start cuts it short
        if (pick == 0 && n_pay > 0)
        begin
            n_pay = $urandom_range(0, n_pay - 1);
        end
        send_start(OPC_W'($urandom), len, $urandom);
        repeat (n_pay) send_payload(byte_t'($urandom));
        // stray bytes after the frame
        if (pick == 1)
        begin
            repeat ($urandom_range(1, 3)) send_payload(byte_t'($urandom));
        end
    endtask

    task automatic test_directed_frames();
        send_payload(8'hA5);
        send_start(4'h1, '0, 32'hFFFF_FFFF);
        send_payload(8'h00);
        send_start(4'hF, 63'd5, 32'h1234_5678);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);
        send_payload(8'hC3);
        send_payload(8'h7E);
        send_payload(8'h11);
        send_start(4'h2, LEN_SHORT_MAX, 32'h0000_0000);
        send_payload(8'hFF);
        send_start(4'h8, LEN_SHORT_MAX + 1'b1, 32'h8000_0001);
        send_payload(8'h80);
        send_start(4'h9, LEN_MEDIUM_MAX, 32'hDEAD_BEEF);
        send_start(4'hA, LEN_MEDIUM_MAX + 1'b1, 32'h0102_0304);
        send_start(4'h0, {LEN_W{1'b1}}, 32'hA5A5_A5A5);
        send_payload(8'hFF);
        send_start(4'h3, 63'd1, 32'h5A5A_5A5A);
        send_payload(8'h3C);
    endtask

    task automatic test_output_backpressure();
        send_gaps = 1'b0;
        hold_len = 150;
        send_start(4'h2, 63'd40, $urandom);
        repeat (40) send_payload(byte_t'($urandom));
        send_gaps = 1'b1;
    endtask

    task automatic test_random_frames();
        while (sent_items < 390)
        begin
            send_random_frame();
        end
    endtask

    task automatic test_full_rate();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        while (sent_items < 430)
        begin
            send_random_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker, sampled mid-cycle where all signals are settled
    always @(negedge clk)
    begin
        frame_byte_t fb;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_frame_bytes.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    fb = pending_frame_bytes.pop_front();
                    check_field("out_byte", fb.data, m_axis_tdata);
                    check_field("run_last", {7'b0, fb.last}, {7'b0, m_axis_tlast});
                    check_field("frame_end", {7'b0, fb.frame_end},
                                {7'b0, m_axis_tuser[USER_FRAME_END]});
                    check_field("error", {7'b0, fb.err}, {7'b0, m_axis_tuser[USER_ERROR]});
                end
            end
        end
    end

    // sink ready: random stalls plus one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_len > 0)
            begin
                stall_left = hold_len - 1;
                hold_len = 0;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        frame_left = '0;
        frame_key = '0;
        key_pos = 2'd0;
        mismatch_count = 0;
        idle_cycles = 0;
        sent_items = 0;
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        hold_len = 0;
        stall_left = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= MODE_START;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_output_backpressure();
        test_random_frames();
        test_full_rate();
        s_axis_tvalid <= 1'b0;
        wait (pending_frame_bytes.size() == 0);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/wsfe_pkg.sv
rtl/websocket_frame_encoder_core.sv
tb/sv/tb_websocket_frame_encoder_core.sv
